// ===== sv/jsu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package jsu_pkg;

  // Result status codes
  typedef enum logic [2:0] {
    ST_BUSY   = 3'd0,
    ST_DONE   = 3'd1,
    ST_UNTERM = 3'd2,
    ST_BADUNI = 3'd3,
    ST_UNKESC = 3'd4,
    ST_BADHEX = 3'd5
  } status_e;

  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChLowB   = 8'h62;
  localparam logic [7:0] ChLowF   = 8'h66;
  localparam logic [7:0] ChLowN   = 8'h6E;
  localparam logic [7:0] ChLowR   = 8'h72;
  localparam logic [7:0] ChLowT   = 8'h74;
  localparam logic [7:0] ChLowU   = 8'h75;

  localparam logic [7:0] CtlBs  = 8'h08;
  localparam logic [7:0] CtlFf  = 8'h0C;
  localparam logic [7:0] CtlLf  = 8'h0A;
  localparam logic [7:0] CtlCr  = 8'h0D;
  localparam logic [7:0] CtlTab = 8'h09;

  // UTF-8 lead and continuation markers
  localparam logic [7:0] Utf8Lead2 = 8'hC0;
  localparam logic [7:0] Utf8Lead3 = 8'hE0;
  localparam logic [7:0] Utf8Cont  = 8'h80;

  // Hex digit decode: {ok, value}
  function automatic logic [4:0] hex_decode(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/json_string_unescape.sv =====
// The first result word of an input word is registered and shown in the cycle after it is accepted.
// Throughput: one input word per cycle while res_ready_i is high; a \uXXXX escape that encodes to two
//   or three UTF-8 bytes holds the input while the result buffer drains.
// A new input word is taken when the result buffer is empty or its last word leaves now.
// Reset (rst_ni low, asynchronous) empties the result buffer and returns the decoder to
//   waiting for an opening delimiter with the hex collector cleared.
`timescale 1ns / 1ps
`default_nettype none

module json_string_unescape (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       text_end_i,
  output logic            res_valid_o,
  input  wire logic       res_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            out_valid_o,
  output logic [2:0]      status_o,
  output logic            last_o
);

  // Decoder phase. Only four codes are reachable.
  typedef enum logic [1:0] {
    PH_AWAIT = 2'd0,
    PH_BODY  = 2'd1,
    PH_ESC   = 2'd2,
    PH_HEX   = 2'd3
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [1:0]  hex_cnt_q, hex_cnt_d;
  // Only the first three digits are ever held; the fourth completes the code unit.
  logic [11:0] acc_q, acc_d;

  // Result buffer: up to three bytes, shifted toward slot 0 as words leave.
  logic [1:0]  rem_q;
  logic [7:0]  buf0_q, buf1_q, buf2_q;
  logic        fv_q;
  logic [2:0]  st_q;

  // Results of the current input word
  logic [1:0]  r_n;
  logic [7:0]  r_b0, r_b1, r_b2;
  logic        r_fv;
  jsu_pkg::status_e r_st;

  logic        in_fire, res_fire;
  logic [4:0]  hex;
  logic [15:0] cp;

  // Accept while the buffer is empty or its final word is being taken right now.
  assign in_ready_o  = (rem_q == 2'd0) || ((rem_q == 2'd1) && res_ready_i);
  assign in_fire     = in_valid_i && in_ready_o;
  assign res_valid_o = (rem_q != 2'd0);
  assign res_fire    = res_valid_o && res_ready_i;

  assign out_byte_o  = buf0_q;
  assign out_valid_o = fv_q;
  assign status_o    = st_q;
  assign last_o      = (rem_q == 2'd1);

  assign hex = jsu_pkg::hex_decode(data_byte_i);
  assign cp  = {acc_q, hex[3:0]};

  always_comb begin
    phase_d   = phase_q;
    hex_cnt_d = hex_cnt_q;
    acc_d     = acc_q;
    r_n       = 2'd1;
    r_b0      = 8'h00;
    r_b1      = 8'h00;
    r_b2      = 8'h00;
    r_fv      = 1'b0;
    r_st      = jsu_pkg::ST_BUSY;
    unique case (phase_q)
      PH_BODY: begin
        if (text_end_i) begin
          phase_d = PH_AWAIT;
          r_st    = jsu_pkg::ST_UNTERM;
        end else if (data_byte_i == jsu_pkg::ChQuote) begin
          phase_d = PH_AWAIT;
          r_st    = jsu_pkg::ST_DONE;
        end else if (data_byte_i == jsu_pkg::ChBslash) begin
          phase_d = PH_ESC;
        end else begin
          r_b0 = data_byte_i;
          r_fv = 1'b1;
        end
      end
      PH_ESC: begin
        if (text_end_i) begin
          phase_d = PH_AWAIT;
          r_st    = jsu_pkg::ST_UNKESC;
        end else begin
          phase_d = PH_BODY;
          r_fv    = 1'b1;
          unique case (data_byte_i)
            jsu_pkg::ChQuote:  r_b0 = jsu_pkg::ChQuote;
            jsu_pkg::ChBslash: r_b0 = jsu_pkg::ChBslash;
            jsu_pkg::ChSlash:  r_b0 = jsu_pkg::ChSlash;
            jsu_pkg::ChLowB:   r_b0 = jsu_pkg::CtlBs;
            jsu_pkg::ChLowF:   r_b0 = jsu_pkg::CtlFf;
            jsu_pkg::ChLowN:   r_b0 = jsu_pkg::CtlLf;
            jsu_pkg::ChLowR:   r_b0 = jsu_pkg::CtlCr;
            jsu_pkg::ChLowT:   r_b0 = jsu_pkg::CtlTab;
            jsu_pkg::ChLowU: begin
              phase_d   = PH_HEX;
              hex_cnt_d = 2'd0;
              acc_d     = 12'd0;
              r_fv      = 1'b0;
            end
            default: begin
              phase_d = PH_AWAIT;
              r_fv    = 1'b0;
              r_st    = jsu_pkg::ST_UNKESC;
            end
          endcase
        end
      end
      PH_HEX: begin
        if (text_end_i) begin
          phase_d   = PH_AWAIT;
          hex_cnt_d = 2'd0;
          acc_d     = 12'd0;
          r_st      = jsu_pkg::ST_BADUNI;
        end else if (!hex[4]) begin
          phase_d   = PH_AWAIT;
          hex_cnt_d = 2'd0;
          acc_d     = 12'd0;
          r_st      = jsu_pkg::ST_BADHEX;
        end else if (hex_cnt_q != 2'd3) begin
          acc_d     = {acc_q[7:0], hex[3:0]};
          hex_cnt_d = hex_cnt_q + 2'd1;
        end else begin
          // Fourth digit: emit the code unit as UTF-8
          phase_d   = PH_BODY;
          hex_cnt_d = 2'd0;
          acc_d     = 12'd0;
          r_fv      = 1'b1;
          if (cp[15:7] == 9'd0) begin
            r_b0 = {1'b0, cp[6:0]};
          end else if (cp[15:11] == 5'd0) begin
            r_n  = 2'd2;
            r_b0 = jsu_pkg::Utf8Lead2 | {3'b000, cp[10:6]};
            r_b1 = jsu_pkg::Utf8Cont | {2'b00, cp[5:0]};
          end else begin
            r_n  = 2'd3;
            r_b0 = jsu_pkg::Utf8Lead3 | {4'b0000, cp[15:12]};
            r_b1 = jsu_pkg::Utf8Cont | {2'b00, cp[11:6]};
            r_b2 = jsu_pkg::Utf8Cont | {2'b00, cp[5:0]};
          end
        end
      end
      default: begin
        // Awaiting the opening delimiter: its value is not checked.
        hex_cnt_d = 2'd0;
        acc_d     = 12'd0;
        if (text_end_i) begin
          phase_d = PH_AWAIT;
          r_st    = jsu_pkg::ST_UNTERM;
        end else begin
          phase_d = PH_BODY;
        end
      end
    endcase
  end

  // Decoder state, buffer fill count and result payload
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_AWAIT;
      hex_cnt_q <= 2'd0;
      acc_q     <= 12'd0;
      rem_q     <= 2'd0;
      buf0_q    <= 8'h00;
      buf1_q    <= 8'h00;
      buf2_q    <= 8'h00;
      fv_q      <= 1'b0;
      st_q      <= jsu_pkg::ST_BUSY;
    end else begin
      if (in_fire) begin
        phase_q   <= phase_d;
        hex_cnt_q <= hex_cnt_d;
        acc_q     <= acc_d;
        rem_q     <= r_n;
        buf0_q    <= r_b0;
        buf1_q    <= r_b1;
        buf2_q    <= r_b2;
        fv_q      <= r_fv;
        st_q      <= r_st;
      end else if (res_fire) begin
        rem_q  <= rem_q - 2'd1;
        buf0_q <= buf1_q;
        buf1_q <= buf2_q;
      end
    end
  end

  // Every accepted word shows a result in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> res_valid_o)
    else $error("no result after accepted input word");

  // A non-final result word is a UTF-8 byte still in progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !last_o) |-> (out_valid_o && status_o == jsu_pkg::ST_BUSY))
    else $error("non-final result word is not a busy data byte");

  // After a non-final word leaves, more words of the same item follow.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_fire && !last_o) |=> (res_valid_o && !in_ready_o) || (res_valid_o && last_o))
    else $error("multi-byte result cut short");

  // The digit counter is only in use while collecting hex digits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PH_HEX) |-> (hex_cnt_q == 2'd0 && acc_q == 12'd0))
    else $error("hex collector not cleared outside a unicode escape");

endmodule

`default_nettype wire

// ===== test/jsu_decode_check.sv =====
`timescale 1ns / 1ps

module jsu_decode_check (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [7:0] data_byte_i,
  input  logic       text_end_i,
  input  logic       res_valid_i,
  input  logic       res_ready_i,
  input  logic [7:0] out_byte_i,
  input  logic       out_valid_i,
  input  logic [2:0] status_i,
  input  logic       last_i,
  output int         pending_o,
  output int         errors_o
);

  typedef enum logic [1:0] {PhAwait, PhBody, PhEsc, PhHex} phase_e;

  typedef struct packed {
    logic [7:0]       data;
    logic             vld;
    jsu_pkg::status_e st;
    logic             lst;
  } result_t;

  phase_e      phase;
  logic [1:0]  nibbles;
  logic [15:0] code;
  result_t     decoded_q[$];
  result_t     want;
  int          mismatches;

  assign errors_o = mismatches;

  task automatic emit(input logic [7:0] data, input logic vld, input jsu_pkg::status_e st,
                      input logic lst);
    result_t r;
    r.data = data;
    r.vld  = vld;
    r.st   = st;
    r.lst  = lst;
    decoded_q = {decoded_q, r};
  endtask

  // quote and every error end the string; next word is a new delimiter
  task automatic close_string(input jsu_pkg::status_e st);
    phase   = PhAwait;
    nibbles = 2'd0;
    code    = 16'h0000;
    emit(8'h00, 1'b0, st, 1'b1);
  endtask

  task automatic decode_word(input logic [7:0] b, input logic e);
    logic [7:0]  esc;
    logic [3:0]  nib;
    logic [15:0] cp;
    case (phase)
      PhBody: begin
        if (e) close_string(jsu_pkg::ST_UNTERM);
        else if (b == jsu_pkg::ChQuote) close_string(jsu_pkg::ST_DONE);
        else if (b == jsu_pkg::ChBslash) begin
          phase = PhEsc;
          emit(8'h00, 1'b0, jsu_pkg::ST_BUSY, 1'b1);
        end else emit(b, 1'b1, jsu_pkg::ST_BUSY, 1'b1);
      end
      PhEsc: begin
        // no mapped escape yields 0x00, so 0x00 marks an unknown letter
        esc = 8'h00;
        if (!e) begin
          case (b)
            jsu_pkg::ChQuote, jsu_pkg::ChBslash, jsu_pkg::ChSlash: esc = b;
            jsu_pkg::ChLowB: esc = jsu_pkg::CtlBs;
            jsu_pkg::ChLowF: esc = jsu_pkg::CtlFf;
            jsu_pkg::ChLowN: esc = jsu_pkg::CtlLf;
            jsu_pkg::ChLowR: esc = jsu_pkg::CtlCr;
            jsu_pkg::ChLowT: esc = jsu_pkg::CtlTab;
            default:         esc = 8'h00;
          endcase
        end
        if (!e && b == jsu_pkg::ChLowU) begin
          phase   = PhHex;
          nibbles = 2'd0;
          code    = 16'h0000;
          emit(8'h00, 1'b0, jsu_pkg::ST_BUSY, 1'b1);
        end else if (esc == 8'h00) close_string(jsu_pkg::ST_UNKESC);
        else begin
          phase = PhBody;
          emit(esc, 1'b1, jsu_pkg::ST_BUSY, 1'b1);
        end
      end
      PhHex: begin
        if (e) close_string(jsu_pkg::ST_BADUNI);
        else if (!((b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h66) ||
                   (b >= 8'h41 && b <= 8'h46))) close_string(jsu_pkg::ST_BADHEX);
        else begin
          nib = (b <= 8'h39) ? b[3:0] : b[3:0] + 4'd9;
          cp  = {code[11:0], nib};
          if (nibbles != 2'd3) begin
            code    = cp;
            nibbles = nibbles + 2'd1;
            emit(8'h00, 1'b0, jsu_pkg::ST_BUSY, 1'b1);
          end else begin
            phase   = PhBody;
            nibbles = 2'd0;
            code    = 16'h0000;
            if (cp <= 16'h007F) emit(cp[7:0], 1'b1, jsu_pkg::ST_BUSY, 1'b1);
            else if (cp <= 16'h07FF) begin
              emit(jsu_pkg::Utf8Lead2 | {3'b000, cp[10:6]}, 1'b1, jsu_pkg::ST_BUSY, 1'b0);
              emit(jsu_pkg::Utf8Cont | {2'b00, cp[5:0]}, 1'b1, jsu_pkg::ST_BUSY, 1'b1);
            end else begin
              emit(jsu_pkg::Utf8Lead3 | {4'b0000, cp[15:12]}, 1'b1, jsu_pkg::ST_BUSY, 1'b0);
              emit(jsu_pkg::Utf8Cont | {2'b00, cp[11:6]}, 1'b1, jsu_pkg::ST_BUSY, 1'b0);
              emit(jsu_pkg::Utf8Cont | {2'b00, cp[5:0]}, 1'b1, jsu_pkg::ST_BUSY, 1'b1);
            end
          end
        end
      end
      default: begin
        if (e) close_string(jsu_pkg::ST_UNTERM);
        else begin
          phase   = PhBody;
          nibbles = 2'd0;
          code    = 16'h0000;
          emit(8'h00, 1'b0, jsu_pkg::ST_BUSY, 1'b1);
        end
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase      = PhAwait;
      nibbles    = 2'd0;
      code       = 16'h0000;
      mismatches = 0;
      decoded_q.delete();
      pending_o <= 0;
    end else begin
      // a result never belongs to the word taken at the same edge
      if (res_valid_i && res_ready_i) begin
        if (decoded_q.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected result: byte %h valid %b status %0d last %b",
                     $realtime, out_byte_i, out_valid_i, status_i, last_i);
          mismatches++;
        end else begin
          want = decoded_q.pop_front();
          if (out_byte_i !== want.data || out_valid_i !== want.vld ||
              status_i !== want.st || last_i !== want.lst) begin
            if (mismatches < 10) begin
              $display("%0t: mismatch: expected byte %h valid %b status %0d last %b",
                       $realtime, want.data, want.vld, want.st, want.lst);
              $display("  got byte %h valid %b status %0d last %b",
                       out_byte_i, out_valid_i, status_i, last_i);
            end
            mismatches++;
          end
        end
      end
      if (in_valid_i && in_ready_i) decode_word(data_byte_i, text_end_i);
      pending_o <= decoded_q.size();
    end
  end

endmodule

// ===== test/json_string_unescape_test.sv =====
`timescale 1ns / 1ps

// Drives JSON string text into the decoder one word at a time and gives the verdict.
// The checker beside the block predicts every result word and counts mismatches.
module json_string_unescape_test;

  localparam int RandomItems = 500;
  // cycles with no word moving on either channel before the run is given up
  localparam int IdleLimit   = 1000;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] data_byte;
  logic       text_end;
  logic       res_valid;
  logic       res_ready;
  logic [7:0] out_byte;
  logic       out_valid;
  logic [2:0] status;
  logic       last;

  int         pending;
  int         errors;
  int         n_sent;
  int         idle_cycles;
  int         stall_draw;
  int         stall_left;
  int         goal;
  int         pick;
  bit         quiet;       // no gaps and no stalls while set
  bit         drained_once;

  json_string_unescape dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .data_byte_i (data_byte),
    .text_end_i  (text_end),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .out_byte_o  (out_byte),
    .out_valid_o (out_valid),
    .status_o    (status),
    .last_o      (last)
  );

  jsu_decode_check u_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .data_byte_i (data_byte),
    .text_end_i  (text_end),
    .res_valid_i (res_valid),
    .res_ready_i (res_ready),
    .out_byte_i  (out_byte),
    .out_valid_i (out_valid),
    .status_i    (status),
    .last_i      (last),
    .pending_o   (pending),
    .errors_o    (errors)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: after each word taken, ready may drop for a randomly drawn stall.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      res_ready  <= 1'b0;
      stall_left <= 0;
    end else if (res_ready) begin
      if (res_valid) begin
        stall_draw = quiet ? 0 : $urandom_range(0, 3);
        if (stall_draw != 0) begin
          res_ready  <= 1'b0;
          stall_left <= stall_draw;
        end
      end
    end else if (stall_left <= 1) begin
      res_ready <= 1'b1;
    end else begin
      stall_left <= stall_left - 1;
    end
  end

  // Watchdog: any word moving on either side restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (res_valid && res_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("FAIL json_string_unescape");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // One input word: random gap first, then hold valid until taken.
  task automatic push_word(input logic [7:0] b, input logic e);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    text_end  <= e;
    do @(posedge clk); while (!in_ready);
    n_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) push_word(s[i], 1'b0);
  endtask

  // hold input back until every predicted result word has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return 8'h30 + {4'h0, v};
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + {4'h0, v} - 8'd10;
  endfunction

  function automatic logic [7:0] escape_letter(input int idx);
    case (idx)
      0:       return jsu_pkg::ChQuote;
      1:       return jsu_pkg::ChBslash;
      2:       return jsu_pkg::ChSlash;
      3:       return jsu_pkg::ChLowB;
      4:       return jsu_pkg::ChLowF;
      5:       return jsu_pkg::ChLowN;
      6:       return jsu_pkg::ChLowR;
      default: return jsu_pkg::ChLowT;
    endcase
  endfunction

  // backslash, u, then the first n hex digits of the code unit
  task automatic send_unicode(input logic [15:0] cp, input int n);
    push_word(jsu_pkg::ChBslash, 1'b0);
    push_word(jsu_pkg::ChLowU, 1'b0);
    for (int i = 0; i < n; i++) push_word(hex_char(cp[15 - 4 * i -: 4]), 1'b0);
  endtask

  // Raw words: any byte, end flag now and then.
  task automatic send_noise();
    int n;
    n = $urandom_range(1, 6);
    repeat (n) push_word(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
  endtask

  // Mostly well-formed strings with random content; some end broken.
  task automatic send_random_string();
    int          tokens;
    int          kind;
    int          tail;
    logic [7:0]  b;
    logic [15:0] cp;
    push_word(8'($urandom_range(0, 255)), 1'b0);   // opening delimiter, any byte
    tokens = $urandom_range(0, 8);
    for (int k = 0; k < tokens; k++) begin
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
        do b = 8'($urandom_range(0, 255));
        while (b == jsu_pkg::ChQuote || b == jsu_pkg::ChBslash);
        push_word(b, 1'b0);
      end else if (kind < 7) begin
        push_word(jsu_pkg::ChBslash, 1'b0);
        push_word(escape_letter($urandom_range(0, 7)), 1'b0);
      end else begin
        // one, two or three UTF-8 bytes; surrogate halves included
        case ($urandom_range(0, 2))
          0:       cp = 16'($urandom_range(0, 'h7F));
          1:       cp = 16'($urandom_range('h80, 'h7FF));
          default: cp = 16'($urandom_range('h800, 'hFFFF));
        endcase
        send_unicode(cp, 4);
      end
    end
    tail = $urandom_range(0, 15);
    if (tail < 10) begin
      push_word(jsu_pkg::ChQuote, 1'b0);
    end else if (tail == 10) begin
      push_word(8'($urandom_range(0, 255)), 1'b1);            // end inside the body
    end else if (tail == 11) begin
      push_word(jsu_pkg::ChBslash, 1'b0);
      push_word(8'($urandom_range(0, 255)), 1'b1);            // end after backslash
    end else if (tail == 12) begin
      do b = 8'($urandom_range(0, 255));
      while (b inside {jsu_pkg::ChQuote, jsu_pkg::ChBslash, jsu_pkg::ChSlash,
                       jsu_pkg::ChLowB, jsu_pkg::ChLowF, jsu_pkg::ChLowN,
                       jsu_pkg::ChLowR, jsu_pkg::ChLowT, jsu_pkg::ChLowU});
      push_word(jsu_pkg::ChBslash, 1'b0);
      push_word(b, 1'b0);                                     // unknown escape letter
    end else if (tail == 13) begin
      send_unicode(16'($urandom_range(0, 'hFFFF)), $urandom_range(0, 3));
      push_word(8'($urandom_range(0, 255)), 1'b1);            // end among hex digits
    end else begin
      do b = 8'($urandom_range(0, 255));
      while ((b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h66) ||
             (b >= 8'h41 && b <= 8'h46));
      send_unicode(16'($urandom_range(0, 'hFFFF)), $urandom_range(0, 3));
      push_word(b, 1'b0);                                     // bad hex digit
    end
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    data_byte <= 8'h00;
    text_end  <= 1'b0;
    quiet        = 1'b0;
    n_sent       = 0;
    drained_once = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // end of text before any string: unterminated, still awaiting a delimiter
    push_word(8'h00, 1'b1);
    // delimiter is not checked; body byte 0x00; three-byte escape; end in body
    push_word(8'hFF, 1'b0);
    push_word(8'h00, 1'b0);
    send_text("\\uFfFf");
    push_word(8'hFF, 1'b1);
    // \u0000 gives a valid zero byte; then end right after a backslash
    send_text("\"\\u0000\\");
    push_word(8'hA5, 1'b1);
    // end while collecting hex digits
    send_text("\"\\u07f");
    push_word(8'h5A, 1'b1);
    // unknown escape, then a bad hex digit, then a two-byte escape closed by a quote
    send_text("\"\\q");
    send_text("\"\\u0G");
    send_text("\"\\u07FF\"");

    goal = n_sent + RandomItems;
    while (n_sent < goal) begin
      quiet = ($urandom_range(0, 5) == 0);
      pick  = $urandom_range(0, 9);
      if (pick == 0) push_word(8'($urandom_range(0, 255)), 1'b1);
      else if (pick == 1) send_noise();
      else send_random_string();
      // once mid-run, let the result side empty out completely
      if (!drained_once && n_sent >= goal - RandomItems / 2) begin
        wait_drained();
        drained_once = 1'b1;
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);   // catch stray result words
    if (errors == 0) begin
      $display("PASS json_string_unescape");
    end else begin
      $display("FAIL json_string_unescape");
    end
    $finish;
  end

endmodule
